### sv/tfcl_pkg.sv
// shared constants, types and helpers of the tolerance flood labeler
package tfcl_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int STACK_DEPTH = 16384;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);

    localparam int DIM_W   = 7;
    localparam int TOL_W   = 9;
    localparam int PIX_W   = 8;
    localparam int LABEL_W = 12;
    localparam int COUNT_W = 13;
    localparam int OP_W    = 2;

    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [TOL_W-1:0] tolerance;
        logic [PIX_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic               visited;
        logic [LABEL_W-1:0] label;
    } lab_entry_t;

    typedef struct packed {
        logic [YW-1:0] y;
        logic [XW-1:0] x;
    } stk_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } pix_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        lab_entry_t        data;
    } lab_wr_t;

    typedef struct packed {
        logic              en;
        logic [STK_AW-1:0] addr;
        stk_entry_t        data;
    } stk_wr_t;

endpackage

### sv/tfcl_ram.sv
// generic simple dual-port ram with registered read data
module tfcl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/tfcl_cfg.sv
// apb register file for image size, tolerance and seed threshold
module tfcl_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tfcl_pkg::CFG_AW-1:0] paddr,
    input  logic [tfcl_pkg::CFG_DW-1:0] pwdata,
    output logic [tfcl_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output tfcl_pkg::cfg_t             cfg
);
    import tfcl_pkg::*;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    localparam logic [DIM_W-1:0] WIDTH_RST     = DIM_W'(64);
    localparam logic [DIM_W-1:0] HEIGHT_RST    = DIM_W'(64);
    localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(3);
    localparam logic [PIX_W-1:0] THRESHOLD_RST = PIX_W'(20);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [TOL_W-1:0] tolerance_reg;
    logic [PIX_W-1:0] threshold_reg;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            tolerance_reg <= TOLERANCE_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg     <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= pwdata[DIM_W-1:0];
                REG_TOLERANCE:    tolerance_reg <= pwdata[TOL_W-1:0];
                REG_THRESHOLD:    threshold_reg <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_reg);
            REG_TOLERANCE:    prdata = CFG_DW'(tolerance_reg);
            REG_THRESHOLD:    prdata = CFG_DW'(threshold_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg = '{width: width_reg, height: height_reg,
                   tolerance: tolerance_reg, threshold: threshold_reg};

endmodule

### sv/tfcl_ctrl.sv
// request handling, clearing pass, raster scan and stack-driven flood sequencer
module tfcl_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tfcl_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tfcl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tfcl_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tfcl_pkg::M_TDATA_W-1:0] m_tdata,
    output tfcl_pkg::pix_wr_t             pix_wr,
    output logic [tfcl_pkg::ADDR_W-1:0]   pix_raddr,
    input  logic [tfcl_pkg::PIX_W-1:0]    pix_rdata,
    output tfcl_pkg::lab_wr_t             lab_wr,
    output logic [tfcl_pkg::ADDR_W-1:0]   lab_raddr,
    input  tfcl_pkg::lab_entry_t          lab_rdata,
    output tfcl_pkg::stk_wr_t             stk_wr,
    output logic [tfcl_pkg::STK_AW-1:0]   stk_raddr,
    input  tfcl_pkg::stk_entry_t          stk_rdata
);
    import tfcl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_RDOUT     = 11'b000_0000_0010,
        S_CLEAR     = 11'b000_0000_0100,
        S_SCAN_RD   = 11'b000_0000_1000,
        S_SCAN_CHK  = 11'b000_0001_0000,
        S_POP       = 11'b000_0010_0000,
        S_CUR_LATCH = 11'b000_0100_0000,
        S_CUR_RD    = 11'b000_1000_0000,
        S_CUR_CHK   = 11'b001_0000_0000,
        S_NB_RD     = 11'b010_0000_0000,
        S_NB_CHK    = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        NB_UP    = 2'd0,
        NB_DOWN  = 2'd1,
        NB_LEFT  = 2'd2,
        NB_RIGHT = 2'd3
    } nb_dir_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] vmax);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > vmax) begin
            r = vmax;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] idx_of(input logic [YW-1:0] y,
                                                 input logic [XW-1:0] x,
                                                 input logic [DIM_W-1:0] w);
        logic [YW+DIM_W-1:0] prod;
        prod = (YW+DIM_W)'(y) * (YW+DIM_W)'(w);
        return ADDR_W'(prod + (YW+DIM_W)'(x));
    endfunction

    state_t            state_reg, state_next;
    nb_dir_t           nb_sel_reg, nb_sel_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [ADDR_W-1:0] sidx_reg, sidx_next;
    logic [XW-1:0]     sx_reg, sx_next;
    logic [YW-1:0]     sy_reg, sy_next;
    logic [XW-1:0]     cx_reg, cx_next;
    logic [YW-1:0]     cy_reg, cy_next;
    logic [ADDR_W-1:0] cur_idx_reg, cur_idx_next;
    logic [XW-1:0]     nx_reg, nx_next;
    logic [YW-1:0]     ny_reg, ny_next;
    logic [PIX_W-1:0]  cur_pix_reg, cur_pix_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [COUNT_W-1:0] comp_reg, comp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic              cleared_reg, cleared_next;
    logic              out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0] out_label_reg, out_label_next;
    logic              out_reached_reg, out_reached_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [ADDR_W-1:0] in_addr;
    logic [PIX_W-1:0]  in_value;
    opcode_t           in_op;
    logic              in_fire;
    logic              advance;
    logic              scan_row_end;
    logic              scan_last;
    logic              nb_exists;
    logic [ADDR_W-1:0] nb_idx;
    logic [XW-1:0]     nb_x;
    logic [YW-1:0]     nb_y;
    logic [PIX_W-1:0]  diff;
    logic              nb_join;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_value = s_tdata[ADDR_W +: PIX_W];
    assign in_op    = opcode_t'(s_tuser);

    assign scan_row_end = (DIM_W'(sx_reg) + DIM_W'(1)) == w_reg;
    assign scan_last    = scan_row_end && ((DIM_W'(sy_reg) + DIM_W'(1)) == h_reg);

    // neighbour in the current direction, indexed off the current pixel
    always_comb begin
        nb_exists = 1'b0;
        nb_idx    = cur_idx_reg;
        nb_x      = cx_reg;
        nb_y      = cy_reg;
        case (nb_sel_reg)
            NB_UP: begin
                nb_exists = cy_reg != '0;
                nb_idx    = cur_idx_reg - ADDR_W'(w_reg);
                nb_y      = cy_reg - YW'(1);
            end
            NB_DOWN: begin
                nb_exists = (DIM_W'(cy_reg) + DIM_W'(1)) < h_reg;
                nb_idx    = cur_idx_reg + ADDR_W'(w_reg);
                nb_y      = cy_reg + YW'(1);
            end
            NB_LEFT: begin
                nb_exists = cx_reg != '0;
                nb_idx    = cur_idx_reg - ADDR_W'(1);
                nb_x      = cx_reg - XW'(1);
            end
            NB_RIGHT: begin
                nb_exists = (DIM_W'(cx_reg) + DIM_W'(1)) < w_reg;
                nb_idx    = cur_idx_reg + ADDR_W'(1);
                nb_x      = cx_reg + XW'(1);
            end
            default: ;
        endcase
    end

    assign diff    = (cur_pix_reg > pix_rdata) ? cur_pix_reg - pix_rdata
                                               : pix_rdata - cur_pix_reg;
    assign nb_join = !lab_rdata.visited && (TOL_W'(diff) < cfg.tolerance);

    always_comb begin
        state_next       = state_reg;
        nb_sel_next      = nb_sel_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        clr_idx_next     = clr_idx_reg;
        sidx_next        = sidx_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cur_idx_next     = cur_idx_reg;
        nx_next          = nx_reg;
        ny_next          = ny_reg;
        cur_pix_next     = cur_pix_reg;
        sp_next          = sp_reg;
        comp_next        = comp_reg;
        count_next       = count_reg;
        cleared_next     = cleared_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_label_next   = out_label_reg;
        out_reached_next = out_reached_reg;
        out_count_next   = out_count_reg;

        s_tready  = 1'b0;
        in_fire   = 1'b0;
        advance   = 1'b0;
        pix_wr    = '0;
        lab_wr    = '0;
        stk_wr    = '0;
        pix_raddr = sidx_reg;
        lab_raddr = sidx_reg;
        stk_raddr = STK_AW'(sp_reg - SP_W'(1));

        case (state_reg)
            S_IDLE: begin
                s_tready  = !out_valid_reg || m_tready;
                in_fire   = s_tvalid && s_tready;
                lab_raddr = in_addr;
                if (in_fire) begin
                    case (in_op)
                        OP_WRITE: begin
                            pix_wr           = '{en: 1'b1, addr: in_addr, data: in_value};
                            out_valid_next   = 1'b1;
                            out_label_next   = '0;
                            out_reached_next = 1'b0;
                            out_count_next   = count_reg;
                        end
                        OP_RUN: begin
                            w_next       = clamp_dim(cfg.width, DIM_W'(MAX_WIDTH));
                            h_next       = clamp_dim(cfg.height, DIM_W'(MAX_HEIGHT));
                            clr_idx_next = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_READ: begin
                            state_next = S_RDOUT;
                        end
                        default: begin
                            out_valid_next   = 1'b1;
                            out_label_next   = '0;
                            out_reached_next = 1'b0;
                            out_count_next   = count_reg;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                // label store holds garbage until the first clearing pass
                out_valid_next   = 1'b1;
                out_label_next   = cleared_reg ? lab_rdata.label : '0;
                out_reached_next = cleared_reg && lab_rdata.visited;
                out_count_next   = count_reg;
                state_next       = S_IDLE;
            end
            S_CLEAR: begin
                lab_wr       = '{en: 1'b1, addr: clr_idx_reg, data: '0};
                clr_idx_next = clr_idx_reg + ADDR_W'(1);
                if (clr_idx_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    cleared_next = 1'b1;
                    sidx_next    = '0;
                    sx_next      = '0;
                    sy_next      = '0;
                    comp_next    = '0;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                pix_raddr  = sidx_reg;
                lab_raddr  = sidx_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!lab_rdata.visited && pix_rdata > cfg.threshold) begin
                    stk_wr     = '{en: 1'b1, addr: '0, data: '{y: sy_reg, x: sx_reg}};
                    sp_next    = SP_W'(1);
                    state_next = S_POP;
                end else begin
                    advance = 1'b1;
                end
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    comp_next = (comp_reg == COUNT_MAX) ? comp_reg : comp_reg + COUNT_W'(1);
                    advance   = 1'b1;
                end else begin
                    stk_raddr  = STK_AW'(sp_reg - SP_W'(1));
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = S_CUR_LATCH;
                end
            end
            S_CUR_LATCH: begin
                cy_next      = stk_rdata.y;
                cx_next      = stk_rdata.x;
                cur_idx_next = idx_of(stk_rdata.y, stk_rdata.x, w_reg);
                state_next   = S_CUR_RD;
            end
            S_CUR_RD: begin
                pix_raddr  = cur_idx_reg;
                lab_raddr  = cur_idx_reg;
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK: begin
                if (lab_rdata.visited) begin
                    state_next = S_POP;
                end else begin
                    lab_wr = '{en: 1'b1, addr: cur_idx_reg,
                               data: '{visited: 1'b1, label: comp_reg[LABEL_W-1:0]}};
                    cur_pix_next = pix_rdata;
                    nb_sel_next  = NB_UP;
                    state_next   = S_NB_RD;
                end
            end
            S_NB_RD: begin
                pix_raddr = nb_idx;
                lab_raddr = nb_idx;
                if (nb_exists) begin
                    nx_next    = nb_x;
                    ny_next    = nb_y;
                    state_next = S_NB_CHK;
                end else if (nb_sel_reg == NB_RIGHT) begin
                    state_next = S_POP;
                end else begin
                    nb_sel_next = nb_dir_t'(nb_sel_reg + 2'd1);
                end
            end
            S_NB_CHK: begin
                // a push onto a full stack is dropped
                if (nb_join && sp_reg != SP_W'(STACK_DEPTH)) begin
                    stk_wr  = '{en: 1'b1, addr: sp_reg[STK_AW-1:0],
                                data: '{y: ny_reg, x: nx_reg}};
                    sp_next = sp_reg + SP_W'(1);
                end
                if (nb_sel_reg == NB_RIGHT) begin
                    state_next = S_POP;
                end else begin
                    nb_sel_next = nb_dir_t'(nb_sel_reg + 2'd1);
                    state_next  = S_NB_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // step the raster scan, or finish the run on the last pixel
        if (advance) begin
            if (scan_last) begin
                count_next       = comp_next;
                out_valid_next   = 1'b1;
                out_label_next   = '0;
                out_reached_next = 1'b0;
                out_count_next   = comp_next;
                state_next       = S_IDLE;
            end else begin
                sidx_next = sidx_reg + ADDR_W'(1);
                if (scan_row_end) begin
                    sx_next = '0;
                    sy_next = sy_reg + YW'(1);
                end else begin
                    sx_next = sx_reg + XW'(1);
                end
                state_next = S_SCAN_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            nb_sel_reg    <= NB_UP;
            sp_reg        <= '0;
            comp_reg      <= '0;
            count_reg     <= '0;
            cleared_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nb_sel_reg    <= nb_sel_next;
            sp_reg        <= sp_next;
            comp_reg      <= comp_next;
            count_reg     <= count_next;
            cleared_reg   <= cleared_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg           <= w_next;
        h_reg           <= h_next;
        clr_idx_reg     <= clr_idx_next;
        sidx_reg        <= sidx_next;
        sx_reg          <= sx_next;
        sy_reg          <= sy_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        cur_idx_reg     <= cur_idx_next;
        nx_reg          <= nx_next;
        ny_reg          <= ny_next;
        cur_pix_reg     <= cur_pix_next;
        out_label_reg   <= out_label_next;
        out_reached_reg <= out_reached_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_reached_reg, out_label_reg});

endmodule

### sv/tolerance_flood_component_labeler.sv
// Labels 4-connected regions of a 64x64 8-bit image held in on-chip memory.
// Each request returns exactly one result. A pixel write is one access to the
// write port of the pixel store and a label read one access to the read port
// of the label store. A run first clears all 4096 entries of the label store,
// one entry a cycle, then scans the active image pixel by pixel; every stack
// pop latches the popped entry and reads its pixel and label, and every newly
// labelled pixel then checks its four neighbours. The run time is set by the
// single read port of the label/visited memory, which every scan, pop and
// neighbour test goes through. Label reads return zero until the first run
// has completed its clearing pass.
module tolerance_flood_component_labeler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfcl_pkg::CFG_AW-1:0]    paddr,
    input  logic [tfcl_pkg::CFG_DW-1:0]    pwdata,
    output logic [tfcl_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tfcl_pkg::S_TDATA_W-1:0] s_tdata,  // pixel_address, pixel_value
    input  logic [tfcl_pkg::S_TUSER_W-1:0] s_tuser,  // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tfcl_pkg::M_TDATA_W-1:0] m_tdata   // label, reached, component_count
);
    import tfcl_pkg::*;

    cfg_t              cfg;
    pix_wr_t           pix_wr;
    logic [ADDR_W-1:0] pix_raddr;
    logic [PIX_W-1:0]  pix_rdata;
    lab_wr_t           lab_wr;
    logic [ADDR_W-1:0] lab_raddr;
    lab_entry_t        lab_rdata;
    stk_wr_t           stk_wr;
    logic [STK_AW-1:0] stk_raddr;
    stk_entry_t        stk_rdata;

    tfcl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfcl_ram #(.DEPTH(STORE_DEPTH), .WIDTH(PIX_W)) u_pix_ram (
        .aclk  (aclk),
        .we    (pix_wr.en),
        .waddr (pix_wr.addr),
        .wdata (pix_wr.data),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    tfcl_ram #(.DEPTH(STORE_DEPTH), .WIDTH($bits(lab_entry_t))) u_lab_ram (
        .aclk  (aclk),
        .we    (lab_wr.en),
        .waddr (lab_wr.addr),
        .wdata (lab_wr.data),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    tfcl_ram #(.DEPTH(STACK_DEPTH), .WIDTH($bits(stk_entry_t))) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_wr.en),
        .waddr (stk_wr.addr),
        .wdata (stk_wr.data),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    tfcl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .pix_wr    (pix_wr),
        .pix_raddr (pix_raddr),
        .pix_rdata (pix_rdata),
        .lab_wr    (lab_wr),
        .lab_raddr (lab_raddr),
        .lab_rdata (lab_rdata),
        .stk_wr    (stk_wr),
        .stk_raddr (stk_raddr),
        .stk_rdata (stk_rdata)
    );

endmodule

### tb/tb.sv
// self-checking stream testbench for the tolerance flood component labeler
module tb;
    import tfcl_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int NUM_SETTINGS   = 11;

    localparam logic [CFG_AW-1:0] REG_WIDTH     = 4'd0;
    localparam logic [CFG_AW-1:0] REG_HEIGHT    = 4'd4;
    localparam logic [CFG_AW-1:0] REG_TOLERANCE = 4'd8;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 4'd12;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               reached;
        logic [COUNT_W-1:0] count;
    } reply_t;

    typedef struct {
        opcode_t           op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
    } request_t;

    typedef struct {
        int w;
        int h;
        int tol;
        int thr;
        int n;
    } setting_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [CFG_AW-1:0]    paddr    = '0;
    logic [CFG_DW-1:0]    pwdata   = '0;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // pixel_address, pixel_value
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // label, reached, component_count

    tolerance_flood_component_labeler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // image model of the labeler
    logic [DIM_W-1:0]   cfg_w   = 7'd64;
    logic [DIM_W-1:0]   cfg_h   = 7'd64;
    logic [TOL_W-1:0]   cfg_tol = 9'd3;
    logic [PIX_W-1:0]   cfg_thr = 8'd20;
    bit   [PIX_W-1:0]   img_px    [STORE_DEPTH];
    bit   [LABEL_W-1:0] img_label [STORE_DEPTH];
    bit                 img_seen  [STORE_DEPTH];
    bit   [ADDR_W-1:0]  fill_stack [STACK_DEPTH];
    int                 fill_top;
    bit   [COUNT_W-1:0] last_count;

    request_t request_queue[$];
    reply_t   pending_replies[$];
    request_t next_req;
    reply_t   want;
    int       errors   = 0;
    int       issued   = 0;
    int       answered = 0;
    int       send_idle = 0;
    int       recv_idle = 0;
    int       stall_cycles = 0;
    int       gen_area;
    bit       px_written [STORE_DEPTH];

    int seed_fixture [12] = '{30, 31, 10, 200,
                              29,  5, 12, 201,
                              18, 19, 21, 255};

    setting_t plan [NUM_SETTINGS] = '{
        '{  0,   9,   3,  20, 120},
        '{127,   3,  10,  50, 150},
        '{  2, 127,   5,  30, 150},
        '{  6,   0,   1,   0, 100},
        '{  8,   8, 256, 255, 150},
        '{  8,   8, 511,   0, 150},
        '{ 16,   5,   0,  10, 150},
        '{ 64,   3,   4, 100, 150},
        '{  1,  64,   8,  20, 150},
        '{ 12,  10,   6,  60, 200},
        '{ 20,  15,  40, 128, 200}
    };

    function automatic int active_dim(int v, int lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic void fill_push(int idx);
        if (fill_top < STACK_DEPTH) begin
            fill_stack[fill_top] = idx[ADDR_W-1:0];
            fill_top++;
        end
    endfunction

    function automatic void fill_try(int cur, int nb);
        int a;
        int b;
        int diff;
        a = img_px[cur];
        b = img_px[nb];
        diff = (a > b) ? a - b : b - a;
        if (!img_seen[nb] && diff < cfg_tol)
            fill_push(nb);
    endfunction

    function automatic void grow_region(int seed, int w, int h, int comp);
        int cur;
        int cx;
        int cy;
        fill_top = 0;
        fill_push(seed);
        while (fill_top > 0) begin
            fill_top--;
            cur = fill_stack[fill_top];
            if (cur >= STORE_DEPTH || img_seen[cur])
                continue;
            img_seen[cur] = 1'b1;
            img_label[cur] = comp[LABEL_W-1:0];
            cx = cur % w;
            cy = cur / w;
            // neighbour order sets the stack order, keep it fixed
            if (cy > 0)
                fill_try(cur, cur - w);
            if (cy + 1 < h)
                fill_try(cur, cur + w);
            if (cx > 0)
                fill_try(cur, cur - 1);
            if (cx + 1 < w)
                fill_try(cur, cur + 1);
        end
    endfunction

    function automatic void label_image();
        int w;
        int h;
        int comp;
        int idx;
        w = active_dim(cfg_w, MAX_WIDTH);
        h = active_dim(cfg_h, MAX_HEIGHT);
        comp = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            img_label[i] = '0;
            img_seen[i] = 1'b0;
        end
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                idx = y * w + x;
                if (!img_seen[idx] && img_px[idx] > cfg_thr) begin
                    grow_region(idx, w, h, comp);
                    comp++;
                end
            end
        end
        last_count = (comp > COUNT_MAX) ? COUNT_MAX : comp[COUNT_W-1:0];
    endfunction

    function automatic reply_t labeler_reply(opcode_t op, logic [ADDR_W-1:0] addr,
                                             logic [PIX_W-1:0] value);
        reply_t r;
        r = '0;
        case (op)
            OP_WRITE: img_px[addr] = value;
            OP_RUN:   label_image();
            OP_READ: begin
                r.label = img_label[addr];
                r.reached = img_seen[addr];
            end
            default: ;
        endcase
        r.count = last_count;
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_replies.push_back(labeler_reply(opcode_t'(s_tuser),
                    s_tdata[ADDR_W-1:0], s_tdata[ADDR_W+PIX_W-1:ADDR_W]));
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_req.op;
                    s_tdata <= {{(S_TDATA_W-ADDR_W-PIX_W){1'b0}}, next_req.value,
                                next_req.addr};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                answered++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: result with no request pending: %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tdata[LABEL_W-1:0] !== want.label) begin
                        $display("%0t: label expected %0d actual %0d", $time,
                                 want.label, m_tdata[LABEL_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[LABEL_W] !== want.reached) begin
                        $display("%0t: reached expected %0d actual %0d", $time,
                                 want.reached, m_tdata[LABEL_W]);
                        errors++;
                    end
                    if (m_tdata[LABEL_W+COUNT_W:LABEL_W+1] !== want.count) begin
                        $display("%0t: component_count expected %0d actual %0d", $time,
                                 want.count, m_tdata[LABEL_W+COUNT_W:LABEL_W+1]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void queue_request(opcode_t op, int addr, int value);
        request_t q;
        q.op = op;
        q.addr = addr[ADDR_W-1:0];
        q.value = value[PIX_W-1:0];
        request_queue.push_back(q);
        issued++;
        if (op == OP_WRITE)
            px_written[addr] = 1'b1;
    endfunction

    // clustered levels so that floods actually spread
    function automatic int pick_pixel();
        int levels [4] = '{12, 70, 140, 235};
        if ($urandom_range(9) < 7)
            return levels[$urandom_range(3)] + $urandom_range(4);
        return $urandom_range(255);
    endfunction

    function automatic int pick_addr();
        if ($urandom_range(99) < 85)
            return $urandom_range(gen_area - 1);
        return $urandom_range(STORE_DEPTH - 1);
    endfunction

    task automatic cfg_write(logic [CFG_AW-1:0] addr, int value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_WIDTH:     cfg_w = value[DIM_W-1:0];
            REG_HEIGHT:    cfg_h = value[DIM_W-1:0];
            REG_TOLERANCE: cfg_tol = value[TOL_W-1:0];
            REG_THRESHOLD: cfg_thr = value[PIX_W-1:0];
            default: ;
        endcase
    endtask

    // sender holds off until every reply is back and the block is quiet
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (answered < issued);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(int w, int h, int tol, int thr);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_TOLERANCE, tol);
        cfg_write(REG_THRESHOLD, thr);
        gen_area = active_dim(w, MAX_WIDTH) * active_dim(h, MAX_HEIGHT);
    endtask

    task automatic run_phase(setting_t s);
        int pick;
        apply_setting(s.w, s.h, s.tol, s.thr);
        // a run may only cover pixels that hold written data
        for (int i = 0; i < gen_area; i++) begin
            if (!px_written[i])
                queue_request(OP_WRITE, i, pick_pixel());
        end
        queue_request(OP_RUN, $urandom_range(STORE_DEPTH - 1), $urandom_range(255));
        for (int k = 0; k < s.n; k++) begin
            pick = $urandom_range(99);
            if (pick < 4)
                queue_request(OP_RUN, $urandom_range(STORE_DEPTH - 1), $urandom_range(255));
            else if (pick < 6)
                queue_request(OP_NOP, $urandom_range(STORE_DEPTH - 1), $urandom_range(255));
            else if (pick < 50)
                queue_request(OP_WRITE, pick_addr(), pick_pixel());
            else
                queue_request(OP_READ, pick_addr(), $urandom_range(255));
        end
        wait_drained();
    endtask

    initial begin
        send_idle = 33;
        recv_idle = 87;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing labelled yet at the reset settings
        queue_request(OP_READ, 0, 0);
        queue_request(OP_NOP, STORE_DEPTH - 1, 255);
        queue_request(OP_WRITE, STORE_DEPTH - 1, 255);
        queue_request(OP_READ, STORE_DEPTH - 1, 0);
        wait_drained();

        // small fixture: seeded regions, a region grown through dark pixels,
        // pixels never reached and a pixel outside the active image
        apply_setting(4, 3, 3, 20);
        for (int i = 0; i < 12; i++)
            queue_request(OP_WRITE, i, seed_fixture[i]);
        queue_request(OP_WRITE, 2048, 0);
        queue_request(OP_RUN, 0, 0);
        queue_request(OP_READ, 0, 0);
        queue_request(OP_READ, 4, 0);
        queue_request(OP_READ, 8, 0);
        queue_request(OP_READ, 2, 0);
        queue_request(OP_READ, 11, 0);
        queue_request(OP_READ, STORE_DEPTH - 1, 0);
        queue_request(OP_NOP, 12'hABC, 8'hC3);
        wait_drained();

        for (int i = 0; i < NUM_SETTINGS; i++) begin
            if (i < 4) begin
                send_idle = 33;
                recv_idle = 87;
            end else if (i < 8) begin
                send_idle = 87;
                recv_idle = 33;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(plan[i]);
        end

        if (errors == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
